FILE: hdl/c816_pkg.sv
// ----------------------------------------------------------------------------
// c816_pkg: shared types and constants for the 65C816 execute unit
// Operation codes, flag positions, vectors and the request/result structs.
// ----------------------------------------------------------------------------
package c816_pkg;

    typedef enum logic [6:0] {
        CMD_ADC = 7'd0,  CMD_AND = 7'd1,  CMD_ASL = 7'd2,  CMD_BCC = 7'd3,
        CMD_BCS = 7'd4,  CMD_BEQ = 7'd5,  CMD_BIT = 7'd6,  CMD_BMI = 7'd7,
        CMD_BNE = 7'd8,  CMD_BPL = 7'd9,  CMD_BRA = 7'd10, CMD_BRK = 7'd11,
        CMD_BRL = 7'd12, CMD_BVC = 7'd13, CMD_BVS = 7'd14, CMD_CLC = 7'd15,
        CMD_CLD = 7'd16, CMD_CLI = 7'd17, CMD_CLV = 7'd18, CMD_CMP = 7'd19,
        CMD_COP = 7'd20, CMD_CPX = 7'd21, CMD_CPY = 7'd22, CMD_DEC = 7'd23,
        CMD_DEX = 7'd24, CMD_DEY = 7'd25, CMD_EOR = 7'd26, CMD_INC = 7'd27,
        CMD_INX = 7'd28, CMD_INY = 7'd29, CMD_LDA = 7'd30, CMD_LDX = 7'd31,
        CMD_LDY = 7'd32, CMD_LSR = 7'd33, CMD_NOP = 7'd34, CMD_ORA = 7'd35,
        CMD_PHA = 7'd36, CMD_PHB = 7'd37, CMD_PHD = 7'd38, CMD_PHK = 7'd39,
        CMD_PHP = 7'd40, CMD_PHX = 7'd41, CMD_PHY = 7'd42, CMD_PLA = 7'd43,
        CMD_PLB = 7'd44, CMD_PLD = 7'd45, CMD_PLP = 7'd46, CMD_PLX = 7'd47,
        CMD_PLY = 7'd48, CMD_REP = 7'd49, CMD_ROL = 7'd50, CMD_ROR = 7'd51,
        CMD_SBC = 7'd52, CMD_SEC = 7'd53, CMD_SED = 7'd54, CMD_SEI = 7'd55,
        CMD_SEP = 7'd56, CMD_STA = 7'd57, CMD_STP = 7'd58, CMD_STX = 7'd59,
        CMD_STY = 7'd60, CMD_STZ = 7'd61, CMD_TAX = 7'd62, CMD_TAY = 7'd63,
        CMD_TCD = 7'd64, CMD_TCS = 7'd65, CMD_TDC = 7'd66, CMD_TRB = 7'd67,
        CMD_TSB = 7'd68, CMD_TSC = 7'd69, CMD_TSX = 7'd70, CMD_TXA = 7'd71,
        CMD_TXS = 7'd72, CMD_TXY = 7'd73, CMD_TYA = 7'd74, CMD_TYX = 7'd75,
        CMD_WAI = 7'd76, CMD_WDM = 7'd77, CMD_XBA = 7'd78, CMD_XCE = 7'd79
    } cmd_t;

    // status bit positions
    localparam int FL_N = 7;
    localparam int FL_V = 6;
    localparam int FL_M = 5;
    localparam int FL_X = 4;
    localparam int FL_D = 3;
    localparam int FL_I = 2;
    localparam int FL_Z = 1;
    localparam int FL_C = 0;

    localparam logic [15:0] VEC_BRK_NATIVE = 16'hFFE6;
    localparam logic [15:0] VEC_BRK_EMUL   = 16'hFFFE;
    localparam logic [15:0] VEC_COP_NATIVE = 16'hFFE4;
    localparam logic [15:0] VEC_COP_EMUL   = 16'hFFF4;
    localparam logic [7:0]  REP_EMUL_MASK  = 8'hCF;
    localparam logic [7:0]  P_RESET        = 8'h34;
    localparam logic [15:0] S_RESET        = 16'h01FF;
    localparam logic [15:0] BCD_NINES      = 16'h9999;

    typedef struct packed {
        logic [6:0]  command;
        logic [15:0] operand;
        logic        bit_immediate;
        logic [7:0]  program_bank;
    } req_t;

    typedef struct packed {
        logic [15:0] data_out;
        logic        data_valid;
        logic        branch_taken;
        logic [15:0] vector_address;
        logic        vector_valid;
        logic        halt;
        logic        waiting;
        logic [7:0]  status_flags;
        logic        emulation;
    } rsp_t;

    // architectural register file
    typedef struct packed {
        logic [15:0] a;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] s;
        logic [15:0] d;
        logic [7:0]  dbr;
        logic [7:0]  p;
        logic        e;
    } regs_t;

    localparam regs_t REGS_RESET = '{a: 16'h0, x: 16'h0, y: 16'h0, s: S_RESET,
                                     d: 16'h0, dbr: 8'h0, p: P_RESET, e: 1'b1};

endpackage

FILE: hdl/cpu_65816_execute_unit.sv
// ----------------------------------------------------------------------------
// cpu_65816_execute_unit: 65C816 execute stage
// Register file, request register and result register around the ALU.
// ----------------------------------------------------------------------------
// One request per cycle while the result slot is free or draining: each accepted request
// is executed from the request register once the result slot is free, updating
// A/X/Y/S/D/DBR/P/E and loading the result register; the rate is limited by the
// register-file update loop through the ALU and by result back-pressure. in_ready
// stays high while the result register is empty or being drained this cycle.
module cpu_65816_execute_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  c816_pkg::req_t   in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output c816_pkg::rsp_t   out_data
);
    import c816_pkg::*;

    regs_t regs_reg;
    regs_t regs_next;
    req_t  req_reg;
    logic  req_valid_reg;
    rsp_t  rsp_next;
    rsp_t  rsp_reg;
    logic  rsp_valid_reg;
    logic  exec_go;

    // stage 2 executes when the result slot is free or draining
    assign exec_go  = req_valid_reg & (~rsp_valid_reg | out_ready);
    assign in_ready = ~req_valid_reg | exec_go;

    c816_alu u_alu (
        .regs      (regs_reg),
        .req       (req_reg),
        .regs_next (regs_next),
        .rsp       (rsp_next)
    );

    // request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_valid_reg <= 1'b0;
        else if (in_ready)
            req_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            req_reg <= in_data;
    end

    // architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            regs_reg <= REGS_RESET;
        else if (exec_go)
            regs_reg <= regs_next;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (exec_go)
            rsp_valid_reg <= 1'b1;
        else if (out_ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (exec_go)
            rsp_reg <= rsp_next;
    end

    assign out_valid = rsp_valid_reg;
    assign out_data  = rsp_reg;

    // checks
    a_emul_mx: assert property (@(posedge clk) disable iff (!rst_n)
        regs_reg.e |-> (regs_reg.p[FL_M] && regs_reg.p[FL_X] && regs_reg.s[15:8] == 8'h01))
        else $error("emulation mode without M/X set or stack page 1");
    a_idx_hi: assert property (@(posedge clk) disable iff (!rst_n)
        regs_reg.p[FL_X] |-> (regs_reg.x[15:8] == 8'h0 && regs_reg.y[15:8] == 8'h0))
        else $error("index high byte set while X flag is 1");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !exec_go |=> $stable(regs_reg))
        else $error("register file changed without execution");
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.status_flags == regs_reg.p && out_data.emulation == regs_reg.e))
        else $error("result flags differ from register state");

endmodule

FILE: hdl/c816_adder.sv
// ----------------------------------------------------------------------------
// c816_adder: binary / BCD adder for ADC and SBC
// Four nibble stages with decimal correction; 8 or 16 bit width.
// ----------------------------------------------------------------------------
module c816_adder (
    input  logic [15:0] a,
    input  logic [15:0] b,
    input  logic        carry_in,
    input  logic        narrow,
    input  logic        decimal,
    output logic [15:0] sum,
    output logic        carry_out,
    output logic        overflow
);
    import c816_pkg::*;

    logic [15:0] mask;
    logic [15:0] am;
    logic [15:0] bm;
    logic [16:0] bin_full;
    logic [15:0] dec_r;
    logic [15:0] dec_vt;
    logic        dec_c;
    logic [15:0] vt;
    logic [15:0] sign;

    assign mask = narrow ? 16'h00FF : 16'hFFFF;
    assign sign = narrow ? 16'h0080 : 16'h8000;
    assign am   = a & mask;
    assign bm   = b & mask;
    assign bin_full = {1'b0, am} + {1'b0, bm} + {16'h0, carry_in};

    // decimal: nibble ripple, four steps; non-BCD digits need the sixth bit
    always_comb
    begin
        logic       c;
        logic [5:0] s;
        c      = carry_in;
        dec_r  = '0;
        dec_vt = '0;
        for (int i = 0; i < 4; i++)
        begin
            s = {2'b0, am[4*i +: 4]} + {2'b0, bm[4*i +: 4]} + {5'h0, c};
            if ((i == 1 && narrow) || (i == 3 && !narrow))
                dec_vt = (dec_r | ({10'h0, s} << (4*i))) & mask;
            if (s > 6'd9)
                s = s + 6'd6;
            if (!(narrow && i >= 2))
            begin
                c = s[5] | s[4];
                dec_r[4*i +: 4] = s[3:0];
            end
        end
        dec_c = c;
    end

    assign sum       = decimal ? dec_r : (bin_full[15:0] & mask);
    assign carry_out = decimal ? dec_c : (narrow ? bin_full[8] : bin_full[16]);
    assign vt        = decimal ? dec_vt : (bin_full[15:0] & mask);
    assign overflow  = |(~(am ^ bm) & (am ^ vt) & sign);

endmodule

FILE: hdl/c816_alu.sv
// ----------------------------------------------------------------------------
// c816_alu: single-pass execute logic
// Computes the next register file and the result from one request.
// ----------------------------------------------------------------------------
module c816_alu (
    input  c816_pkg::regs_t regs,
    input  c816_pkg::req_t  req,
    output c816_pkg::regs_t regs_next,
    output c816_pkg::rsp_t  rsp
);
    import c816_pkg::*;

    logic        mn;
    logic        xn;
    logic [15:0] mm;
    logic [15:0] xm;
    logic [15:0] mtop;
    logic [15:0] op;
    logic [15:0] opm;
    logic [15:0] add_b;
    logic [15:0] add_sum;
    logic        add_c;
    logic        add_v;
    logic [15:0] cmp_a;
    logic [15:0] cmp_diff;
    logic        cmp_xn;
    logic [15:0] cmp_w;

    assign mn   = regs.e | regs.p[FL_M];
    assign xn   = regs.e | regs.p[FL_X];
    assign mm   = mn ? 16'h00FF : 16'hFFFF;
    assign xm   = xn ? 16'h00FF : 16'hFFFF;
    assign mtop = mn ? 16'h0080 : 16'h8000;
    assign op   = req.operand;
    assign opm  = op & mm;

    // SBC adds the ones or nine's complement
    always_comb
    begin
        if (req.command == CMD_SBC)
            add_b = regs.p[FL_D] ? ((BCD_NINES - opm) & mm) : (~op & mm);
        else
            add_b = op;
    end

    c816_adder u_adder (
        .a         (regs.a),
        .b         (add_b),
        .carry_in  (regs.p[FL_C]),
        .narrow    (mn),
        .decimal   (regs.p[FL_D]),
        .sum       (add_sum),
        .carry_out (add_c),
        .overflow  (add_v)
    );

    // compare operand select
    always_comb
    begin
        cmp_xn = xn;
        cmp_a  = regs.x;
        if (req.command == CMD_CMP)
        begin
            cmp_xn = mn;
            cmp_a  = regs.a;
        end
        else if (req.command == CMD_CPY)
            cmp_a = regs.y;
        cmp_w    = cmp_xn ? 16'h00FF : 16'hFFFF;
        cmp_diff = ((cmp_a & cmp_w) - (op & cmp_w)) & cmp_w;
    end

    // main operation decode
    always_comb
    begin
        regs_t       r;
        rsp_t        o;
        logic [15:0] v;
        logic        nz_en;
        logic        nz_nar;
        logic [15:0] nz_v;
        logic        acc_en;
        logic        acc_nar;
        logic [15:0] acc_v;
        logic [7:0]  pmask;

        r       = regs;
        o       = '0;
        v       = '0;
        nz_en   = 1'b0;
        nz_nar  = mn;
        nz_v    = '0;
        acc_en  = 1'b0;
        acc_nar = mn;
        acc_v   = '0;
        pmask   = op[7:0];
        if (regs.e)
            pmask = pmask & REP_EMUL_MASK;

        unique case (req.command)
            CMD_ADC, CMD_SBC:
            begin
                r.p[FL_V] = add_v;
                r.p[FL_C] = add_c;
                nz_en = 1'b1; nz_v = add_sum;
                acc_en = 1'b1; acc_v = add_sum;
            end
            CMD_AND, CMD_ORA, CMD_EOR:
            begin
                if (req.command == CMD_AND)      v = regs.a & op;
                else if (req.command == CMD_ORA) v = regs.a | op;
                else                             v = regs.a ^ op;
                nz_en = 1'b1; nz_v = v;
                acc_en = 1'b1; acc_v = v;
            end
            CMD_ASL:
            begin
                r.p[FL_C] = |(opm & mtop);
                o.data_out = (opm << 1) & mm;
                o.data_valid = 1'b1;
                nz_en = 1'b1; nz_v = o.data_out;
            end
            CMD_LSR:
            begin
                r.p[FL_C] = opm[0];
                o.data_out = opm >> 1;
                o.data_valid = 1'b1;
                nz_en = 1'b1; nz_v = o.data_out;
            end
            CMD_ROL:
            begin
                o.data_out = ((opm << 1) | {15'h0, regs.p[FL_C]}) & mm;
                r.p[FL_C] = |(opm & mtop);
                o.data_valid = 1'b1;
                nz_en = 1'b1; nz_v = o.data_out;
            end
            CMD_ROR:
            begin
                o.data_out = (opm >> 1) | (regs.p[FL_C] ? mtop : 16'h0);
                r.p[FL_C] = opm[0];
                o.data_valid = 1'b1;
                nz_en = 1'b1; nz_v = o.data_out;
            end
            CMD_INC, CMD_DEC:
            begin
                o.data_out = (req.command == CMD_INC) ? ((op + 16'd1) & mm)
                                                      : ((op - 16'd1) & mm);
                o.data_valid = 1'b1;
                nz_en = 1'b1; nz_v = o.data_out;
            end
            CMD_TRB, CMD_TSB:
            begin
                r.p[FL_Z] = ((regs.a & opm) == 16'h0);
                o.data_out = (req.command == CMD_TRB) ? (opm & ~regs.a & mm)
                                                      : ((opm | regs.a) & mm);
                o.data_valid = 1'b1;
            end
            CMD_BIT:
            begin
                if (!req.bit_immediate)
                begin
                    r.p[FL_N] = |(opm & mtop);
                    r.p[FL_V] = |(opm & (mtop >> 1));
                end
                r.p[FL_Z] = ((regs.a & opm) == 16'h0);
            end
            CMD_CMP, CMD_CPX, CMD_CPY:
            begin
                nz_en = 1'b1; nz_nar = cmp_xn; nz_v = cmp_diff;
                r.p[FL_C] = ((cmp_a & cmp_w) >= (op & cmp_w));
            end
            CMD_INX:
            begin
                r.x = (regs.x + 16'd1) & xm;
                nz_en = 1'b1; nz_nar = xn; nz_v = r.x;
            end
            CMD_INY:
            begin
                r.y = (regs.y + 16'd1) & xm;
                nz_en = 1'b1; nz_nar = xn; nz_v = r.y;
            end
            CMD_DEX:
            begin
                r.x = (regs.x - 16'd1) & xm;
                nz_en = 1'b1; nz_nar = xn; nz_v = r.x;
            end
            CMD_DEY:
            begin
                r.y = (regs.y - 16'd1) & xm;
                nz_en = 1'b1; nz_nar = xn; nz_v = r.y;
            end
            CMD_LDA, CMD_PLA:
            begin
                acc_en = 1'b1; acc_v = op;
                nz_en = 1'b1; nz_v = op;
            end
            CMD_LDX, CMD_PLX:
            begin
                r.x = op & xm;
                nz_en = 1'b1; nz_nar = xn; nz_v = op;
            end
            CMD_LDY, CMD_PLY:
            begin
                r.y = op & xm;
                nz_en = 1'b1; nz_nar = xn; nz_v = op;
            end
            CMD_PLB:
            begin
                r.dbr = op[7:0];
                nz_en = 1'b1; nz_nar = 1'b1; nz_v = op;
            end
            CMD_PLD:
            begin
                r.d = op;
                nz_en = 1'b1; nz_nar = 1'b0; nz_v = op;
            end
            CMD_PLP: r.p = op[7:0];
            CMD_PHA, CMD_STA:
            begin
                o.data_out = regs.a & mm; o.data_valid = 1'b1;
            end
            CMD_PHB:
            begin
                o.data_out = {8'h0, regs.dbr}; o.data_valid = 1'b1;
            end
            CMD_PHD:
            begin
                o.data_out = regs.d; o.data_valid = 1'b1;
            end
            CMD_PHK:
            begin
                o.data_out = {8'h0, req.program_bank}; o.data_valid = 1'b1;
            end
            CMD_PHP:
            begin
                o.data_out = {8'h0, regs.p}; o.data_valid = 1'b1;
            end
            CMD_PHX, CMD_STX:
            begin
                o.data_out = regs.x & xm; o.data_valid = 1'b1;
            end
            CMD_PHY, CMD_STY:
            begin
                o.data_out = regs.y & xm; o.data_valid = 1'b1;
            end
            CMD_STZ: o.data_valid = 1'b1;
            CMD_REP: r.p = regs.p & ~pmask;
            CMD_SEP: r.p = regs.p | pmask;
            CMD_CLC: r.p[FL_C] = 1'b0;
            CMD_CLD: r.p[FL_D] = 1'b0;
            CMD_CLI: r.p[FL_I] = 1'b0;
            CMD_CLV: r.p[FL_V] = 1'b0;
            CMD_SEC: r.p[FL_C] = 1'b1;
            CMD_SED: r.p[FL_D] = 1'b1;
            CMD_SEI: r.p[FL_I] = 1'b1;
            CMD_XCE:
            begin
                r.p[FL_C] = regs.e;
                r.e = regs.p[FL_C];
            end
            CMD_XBA:
            begin
                r.a = {regs.a[7:0], regs.a[15:8]};
                nz_en = 1'b1; nz_nar = 1'b1; nz_v = r.a;
            end
            CMD_TAX:
            begin
                r.x = regs.a & xm;
                nz_en = 1'b1; nz_nar = xn; nz_v = r.x;
            end
            CMD_TAY:
            begin
                r.y = regs.a & xm;
                nz_en = 1'b1; nz_nar = xn; nz_v = r.y;
            end
            CMD_TSX:
            begin
                r.x = regs.s & xm;
                nz_en = 1'b1; nz_nar = xn; nz_v = r.x;
            end
            CMD_TXY:
            begin
                r.y = regs.x & xm;
                nz_en = 1'b1; nz_nar = xn; nz_v = r.y;
            end
            CMD_TYX:
            begin
                r.x = regs.y & xm;
                nz_en = 1'b1; nz_nar = xn; nz_v = r.x;
            end
            CMD_TXA:
            begin
                acc_en = 1'b1; acc_v = regs.x;
                nz_en = 1'b1; nz_v = regs.x;
            end
            CMD_TYA:
            begin
                acc_en = 1'b1; acc_v = regs.y;
                nz_en = 1'b1; nz_v = regs.y;
            end
            CMD_TCD:
            begin
                r.d = regs.a;
                nz_en = 1'b1; nz_nar = 1'b0; nz_v = regs.a;
            end
            CMD_TDC:
            begin
                r.a = regs.d;
                nz_en = 1'b1; nz_nar = 1'b0; nz_v = regs.d;
            end
            CMD_TSC:
            begin
                r.a = regs.s;
                nz_en = 1'b1; nz_nar = 1'b0; nz_v = regs.s;
            end
            CMD_TCS: r.s = regs.a;
            CMD_TXS: r.s = regs.x;
            CMD_BCC: o.branch_taken = ~regs.p[FL_C];
            CMD_BCS: o.branch_taken = regs.p[FL_C];
            CMD_BEQ: o.branch_taken = regs.p[FL_Z];
            CMD_BNE: o.branch_taken = ~regs.p[FL_Z];
            CMD_BMI: o.branch_taken = regs.p[FL_N];
            CMD_BPL: o.branch_taken = ~regs.p[FL_N];
            CMD_BVS: o.branch_taken = regs.p[FL_V];
            CMD_BVC: o.branch_taken = ~regs.p[FL_V];
            CMD_BRA, CMD_BRL: o.branch_taken = 1'b1;
            CMD_BRK, CMD_COP:
            begin
                if (req.command == CMD_BRK)
                    o.vector_address = regs.e ? VEC_BRK_EMUL : VEC_BRK_NATIVE;
                else
                    o.vector_address = regs.e ? VEC_COP_EMUL : VEC_COP_NATIVE;
                o.vector_valid = 1'b1;
                r.p[FL_I] = 1'b1;
                r.p[FL_D] = 1'b0;
            end
            CMD_STP: o.halt = 1'b1;
            CMD_WAI: o.waiting = 1'b1;
            default: ;
        endcase

        // accumulator write keeps hidden high byte when narrow
        if (acc_en)
            r.a = acc_nar ? {regs.a[15:8], acc_v[7:0]} : acc_v;
        if (nz_en)
        begin
            r.p[FL_Z] = nz_nar ? (nz_v[7:0] == 8'h0) : (nz_v == 16'h0);
            r.p[FL_N] = nz_nar ? nz_v[7] : nz_v[15];
        end

        // mode settling
        if (r.e)
        begin
            r.p[FL_M] = 1'b1;
            r.p[FL_X] = 1'b1;
            r.s = {8'h01, r.s[7:0]};
        end
        if (r.p[FL_X])
        begin
            r.x = {8'h0, r.x[7:0]};
            r.y = {8'h0, r.y[7:0]};
        end

        o.status_flags = r.p;
        o.emulation    = r.e;
        regs_next = r;
        rsp       = o;
    end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the 65C816 execute unit
// Drives decoded operations through the request channel, predicts each result
// with an in-bench register file model and compares every result field.
// ----------------------------------------------------------------------------
module testbench;
    import c816_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    req_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    rsp_t out_data;

    rsp_t expected_q[$];
    int unsigned error_count = 0;
    int unsigned idle_cycles = 0;
    bit quiet_mode = 1'b0;
    localparam int unsigned WATCHDOG_LIMIT = 2000;

    // predictor copy of the architectural registers
    logic [15:0] pa, px, py, ps, pd;
    logic [7:0] pdbr, pp;
    logic pe;

    cpu_65816_execute_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    always #4 clk = ~clk;

    function automatic void put_nz(logic [15:0] v, bit nar);
        if (nar)
        begin
            pp[FL_Z] = (v[7:0] == 8'h00);
            pp[FL_N] = v[7];
        end
        else
        begin
            pp[FL_Z] = (v == 16'h0000);
            pp[FL_N] = v[15];
        end
    endfunction

    function automatic void load_acc(logic [15:0] v, bit nar);
        if (nar) pa[7:0] = v[7:0];
        else pa = v;
    endfunction

    function automatic void add_acc(logic [15:0] b_in, bit nar);
        logic [16:0] m, sign, a, b, c, r, vt, full, s;
        int digits;
        m = nar ? 17'hFF : 17'hFFFF;
        sign = nar ? 17'h80 : 17'h8000;
        a = {1'b0, pa} & m;
        b = {1'b0, b_in} & m;
        c = pp[FL_C];
        if (pp[FL_D])
        begin
            digits = nar ? 2 : 4;
            r = 0;
            vt = 0;
            for (int i = 0; i < digits; i++)
            begin
                s = ((a >> (4 * i)) & 17'hF) + ((b >> (4 * i)) & 17'hF) + c;
                if (i + 1 == digits) vt = r | ((s << (4 * i)) & m);
                if (s > 9) s = s + 6;
                c = (s > 15) ? 1 : 0;
                r = r | ((s & 17'hF) << (4 * i));
            end
        end
        else
        begin
            full = a + b + c;
            r = full & m;
            vt = r;
            c = nar ? full[8] : full[16];
        end
        pp[FL_V] = ((~(a ^ b) & (a ^ vt) & sign) != 0);
        pp[FL_C] = c[0];
        put_nz(r[15:0], nar);
        load_acc(r[15:0], nar);
    endfunction

    function automatic void cmp_regs(logic [15:0] a, logic [15:0] b, bit nar);
        logic [15:0] m;
        m = nar ? 16'h00FF : 16'hFFFF;
        a = a & m;
        b = b & m;
        put_nz((a - b) & m, nar);
        pp[FL_C] = (a >= b);
    endfunction

    // executes one operation on the predicted state and returns its result
    function automatic rsp_t execute_op(req_t rq);
        rsp_t r;
        bit mn, xn;
        logic [15:0] mm, xm, mtop, op, v;
        logic [7:0] msk;
        r = '0;
        mn = pe | pp[FL_M];
        xn = pe | pp[FL_X];
        mm = mn ? 16'h00FF : 16'hFFFF;
        xm = xn ? 16'h00FF : 16'hFFFF;
        mtop = mn ? 16'h0080 : 16'h8000;
        op = rq.operand;
        case (rq.command)
            CMD_ADC: add_acc(op, mn);
            CMD_SBC:
                if (pp[FL_D]) add_acc(((mn ? 16'h0099 : BCD_NINES) - (op & mm)) & mm, mn);
                else add_acc(~op & mm, mn);
            CMD_AND: begin v = pa & op; put_nz(v, mn); load_acc(v, mn); end
            CMD_ORA: begin v = pa | op; put_nz(v, mn); load_acc(v, mn); end
            CMD_EOR: begin v = pa ^ op; put_nz(v, mn); load_acc(v, mn); end
            CMD_ASL:
            begin
                v = op & mm;
                pp[FL_C] = ((v & mtop) != 0);
                r.data_out = (v << 1) & mm;
                put_nz(r.data_out, mn);
                r.data_valid = 1'b1;
            end
            CMD_LSR:
            begin
                v = op & mm;
                pp[FL_C] = v[0];
                r.data_out = v >> 1;
                put_nz(r.data_out, mn);
                r.data_valid = 1'b1;
            end
            CMD_ROL:
            begin
                v = op & mm;
                r.data_out = ((v << 1) | pp[FL_C]) & mm;
                pp[FL_C] = ((v & mtop) != 0);
                put_nz(r.data_out, mn);
                r.data_valid = 1'b1;
            end
            CMD_ROR:
            begin
                v = op & mm;
                r.data_out = (v >> 1) | (pp[FL_C] ? mtop : 16'h0);
                pp[FL_C] = v[0];
                put_nz(r.data_out, mn);
                r.data_valid = 1'b1;
            end
            CMD_INC:
            begin
                r.data_out = (op + 16'd1) & mm;
                put_nz(r.data_out, mn);
                r.data_valid = 1'b1;
            end
            CMD_DEC:
            begin
                r.data_out = (op - 16'd1) & mm;
                put_nz(r.data_out, mn);
                r.data_valid = 1'b1;
            end
            CMD_TRB:
            begin
                v = op & mm;
                pp[FL_Z] = ((pa & v) == 0);
                r.data_out = v & ~pa & mm;
                r.data_valid = 1'b1;
            end
            CMD_TSB:
            begin
                v = op & mm;
                pp[FL_Z] = ((pa & v) == 0);
                r.data_out = (v | pa) & mm;
                r.data_valid = 1'b1;
            end
            CMD_BIT:
            begin
                v = op & mm;
                if (!rq.bit_immediate)
                begin
                    pp[FL_N] = ((v & mtop) != 0);
                    pp[FL_V] = ((v & (mtop >> 1)) != 0);
                end
                pp[FL_Z] = ((pa & v) == 0);
            end
            CMD_CMP: cmp_regs(pa, op, mn);
            CMD_CPX: cmp_regs(px, op, xn);
            CMD_CPY: cmp_regs(py, op, xn);
            CMD_INX: begin px = (px + 16'd1) & xm; put_nz(px, xn); end
            CMD_INY: begin py = (py + 16'd1) & xm; put_nz(py, xn); end
            CMD_DEX: begin px = (px - 16'd1) & xm; put_nz(px, xn); end
            CMD_DEY: begin py = (py - 16'd1) & xm; put_nz(py, xn); end
            CMD_LDA, CMD_PLA: begin load_acc(op, mn); put_nz(op, mn); end
            CMD_LDX, CMD_PLX: begin px = op & xm; put_nz(op, xn); end
            CMD_LDY, CMD_PLY: begin py = op & xm; put_nz(op, xn); end
            CMD_PLB: begin pdbr = op[7:0]; put_nz(op, 1'b1); end
            CMD_PLD: begin pd = op; put_nz(op, 1'b0); end
            CMD_PLP: pp = op[7:0];
            CMD_PHA, CMD_STA: begin r.data_out = pa & mm; r.data_valid = 1'b1; end
            CMD_PHB: begin r.data_out = {8'h00, pdbr}; r.data_valid = 1'b1; end
            CMD_PHD: begin r.data_out = pd; r.data_valid = 1'b1; end
            CMD_PHK: begin r.data_out = {8'h00, rq.program_bank}; r.data_valid = 1'b1; end
            CMD_PHP: begin r.data_out = {8'h00, pp}; r.data_valid = 1'b1; end
            CMD_PHX, CMD_STX: begin r.data_out = px & xm; r.data_valid = 1'b1; end
            CMD_PHY, CMD_STY: begin r.data_out = py & xm; r.data_valid = 1'b1; end
            CMD_STZ: r.data_valid = 1'b1;
            CMD_REP, CMD_SEP:
            begin
                msk = op[7:0];
                if (pe) msk = msk & REP_EMUL_MASK;
                if (rq.command == CMD_REP) pp = pp & ~msk;
                else pp = pp | msk;
            end
            CMD_CLC: pp[FL_C] = 1'b0;
            CMD_CLD: pp[FL_D] = 1'b0;
            CMD_CLI: pp[FL_I] = 1'b0;
            CMD_CLV: pp[FL_V] = 1'b0;
            CMD_SEC: pp[FL_C] = 1'b1;
            CMD_SED: pp[FL_D] = 1'b1;
            CMD_SEI: pp[FL_I] = 1'b1;
            CMD_XCE:
            begin
                v[0] = pp[FL_C];
                pp[FL_C] = pe;
                pe = v[0];
            end
            CMD_XBA:
            begin
                pa = {pa[7:0], pa[15:8]};
                put_nz(pa, 1'b1);
            end
            CMD_TAX: begin px = pa & xm; put_nz(px, xn); end
            CMD_TAY: begin py = pa & xm; put_nz(py, xn); end
            CMD_TSX: begin px = ps & xm; put_nz(px, xn); end
            CMD_TXY: begin py = px & xm; put_nz(py, xn); end
            CMD_TYX: begin px = py & xm; put_nz(px, xn); end
            CMD_TXA: begin load_acc(px, mn); put_nz(px, mn); end
            CMD_TYA: begin load_acc(py, mn); put_nz(py, mn); end
            CMD_TCD: begin pd = pa; put_nz(pd, 1'b0); end
            CMD_TDC: begin pa = pd; put_nz(pa, 1'b0); end
            CMD_TSC: begin pa = ps; put_nz(pa, 1'b0); end
            CMD_TCS: ps = pa;
            CMD_TXS: ps = px;
            CMD_BCC: r.branch_taken = !pp[FL_C];
            CMD_BCS: r.branch_taken = pp[FL_C];
            CMD_BEQ: r.branch_taken = pp[FL_Z];
            CMD_BNE: r.branch_taken = !pp[FL_Z];
            CMD_BMI: r.branch_taken = pp[FL_N];
            CMD_BPL: r.branch_taken = !pp[FL_N];
            CMD_BVS: r.branch_taken = pp[FL_V];
            CMD_BVC: r.branch_taken = !pp[FL_V];
            CMD_BRA, CMD_BRL: r.branch_taken = 1'b1;
            CMD_BRK, CMD_COP:
            begin
                if (rq.command == CMD_BRK)
                    r.vector_address = pe ? VEC_BRK_EMUL : VEC_BRK_NATIVE;
                else
                    r.vector_address = pe ? VEC_COP_EMUL : VEC_COP_NATIVE;
                r.vector_valid = 1'b1;
                pp[FL_I] = 1'b1;
                pp[FL_D] = 1'b0;
            end
            CMD_STP: r.halt = 1'b1;
            CMD_WAI: r.waiting = 1'b1;
            default: ;
        endcase
        // mode fix-up after every operation
        if (pe)
        begin
            pp[FL_M] = 1'b1;
            pp[FL_X] = 1'b1;
            ps = {8'h01, ps[7:0]};
        end
        if (pp[FL_X])
        begin
            px[15:8] = 8'h00;
            py[15:8] = 8'h00;
        end
        r.status_flags = pp;
        r.emulation = pe;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    // sends one request and records its predicted result
    task automatic send_request(cmd_t c, logic [15:0] op, bit bimm = 1'b0,
                                logic [7:0] pbank = 8'h00);
        req_t rq;
        rq.command = c;
        rq.operand = op;
        rq.bit_immediate = bimm;
        rq.program_bank = pbank;
        while (!quiet_mode && $urandom_range(99) < 12)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= rq;
        expected_q.push_back(execute_op(rq));
        do @(posedge clk); while (!in_ready);
    endtask

    // result side: random stalls, then field-by-field compare
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
            begin
                report_mismatch("unexpected result", out_data.data_out, 16'h0);
            end
            else
            begin
                want = expected_q.pop_front();
                if (out_data.data_out !== want.data_out)
                    report_mismatch("data_out", out_data.data_out, want.data_out);
                if (out_data.data_valid !== want.data_valid)
                    report_mismatch("data_valid", out_data.data_valid, want.data_valid);
                if (out_data.branch_taken !== want.branch_taken)
                    report_mismatch("branch_taken", out_data.branch_taken, want.branch_taken);
                if (out_data.vector_address !== want.vector_address)
                    report_mismatch("vector_address", out_data.vector_address,
                                    want.vector_address);
                if (out_data.vector_valid !== want.vector_valid)
                    report_mismatch("vector_valid", out_data.vector_valid, want.vector_valid);
                if (out_data.halt !== want.halt)
                    report_mismatch("halt", out_data.halt, want.halt);
                if (out_data.waiting !== want.waiting)
                    report_mismatch("waiting", out_data.waiting, want.waiting);
                if (out_data.status_flags !== want.status_flags)
                    report_mismatch("status_flags", out_data.status_flags, want.status_flags);
                if (out_data.emulation !== want.emulation)
                    report_mismatch("emulation", out_data.emulation, want.emulation);
            end
        end
        out_ready <= quiet_mode || ($urandom_range(99) >= 12);
    end

    // watchdog on cycles with no handshake on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic test_reset_state();
        send_request(CMD_PHP, 16'h0000);
        send_request(CMD_TSX, 16'h0000);
        send_request(CMD_BRK, 16'h0000);
        send_request(CMD_COP, 16'h0000);
        send_request(CMD_REP, 16'hFFFF);
    endtask

    task automatic test_native_mode();
        send_request(CMD_CLC, 16'h0000);
        send_request(CMD_XCE, 16'h0000);
        send_request(CMD_REP, 16'h0030);
        send_request(CMD_LDA, 16'h7FFF);
        send_request(CMD_ADC, 16'h0001);
        send_request(CMD_SBC, 16'hFFFF);
        send_request(CMD_SED, 16'h0000);
        send_request(CMD_ADC, 16'h9999);
        send_request(CMD_SBC, 16'h0001);
        send_request(CMD_BIT, 16'hC000, 1'b0);
        send_request(CMD_BIT, 16'h0000, 1'b1);
        send_request(CMD_LDX, 16'hFFFF);
        send_request(CMD_SEP, 16'h0010);
        send_request(CMD_STX, 16'h0000);
        send_request(CMD_BRK, 16'h0000);
        send_request(CMD_COP, 16'h0000);
        send_request(CMD_PHK, 16'h0000, 1'b0, 8'hFF);
        send_request(CMD_STP, 16'h0000);
        send_request(CMD_WAI, 16'h0000);
        send_request(cmd_t'(7'd127), 16'hFFFF, 1'b1, 8'hFF);
        send_request(CMD_SEC, 16'h0000);
        send_request(CMD_XCE, 16'h0000);
    endtask

    task automatic test_random_ops();
        cmd_t c;
        logic [15:0] op;
        for (int n = 0; n < 2000; n++)
        begin
            quiet_mode = (n >= 800 && n < 1000);
            if ($urandom_range(99) < 4) c = cmd_t'($urandom_range(127, 80));
            else c = cmd_t'($urandom_range(79));
            case ($urandom_range(3))
                0: op = 16'h0000;
                1: op = 16'hFFFF;
                default: op = $urandom_range(16'hFFFF);
            endcase
            // keep emulation mode from dominating: leave it readily
            if (c == CMD_XCE && $urandom_range(1)) send_request(CMD_CLC, 16'h0000);
            send_request(c, op, $urandom_range(1), $urandom_range(255));
        end
        quiet_mode = 1'b0;
    endtask

    initial
    begin
        ps = S_RESET; pa = 0; px = 0; py = 0; pd = 0; pdbr = 0; pp = P_RESET; pe = 1'b1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_native_mode();
        test_random_ops();
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (error_count == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end
endmodule
